FILE: hw/rtl/ethernet_header_classifier_unit_assert.svh
// Assertion macros shared by the checker files of the header classifier.
// No dependencies; include by bare file name.
`ifndef ETHERNET_HEADER_CLASSIFIER_UNIT_ASSERT_SVH
`define ETHERNET_HEADER_CLASSIFIER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define EHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define EHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ehc_pkg.sv
// Shared types and constants of the Ethernet header classifier.
// No dependencies.
package ehc_pkg;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] DNS_PORT_RST  = 16'd53;
  localparam logic [15:0] HTTP_PORT_RST = 16'd80;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] IPP_ICMP = 8'd1;
  localparam logic [7:0] IPP_IGMP = 8'd2;
  localparam logic [7:0] IPP_TCP  = 8'd6;
  localparam logic [7:0] IPP_UDP  = 8'd17;
  localparam logic [7:0] IPP_ICMP6 = 8'd58;
  localparam logic [7:0] IPP_IGRP = 8'd88;
  localparam logic [7:0] IPP_OSPF = 8'd89;

  localparam logic CFG_DNS_PORT = 1'b0;
  localparam logic CFG_HTTP_PORT = 1'b1;

  typedef enum logic [3:0] {
    CLS_OTHER = 4'd0, CLS_ARP = 4'd1, CLS_IPV4 = 4'd2, CLS_IPV6 = 4'd3,
    CLS_ICMP = 4'd4, CLS_IGMP = 4'd5, CLS_TCP = 4'd6, CLS_UDP = 4'd7,
    CLS_IGRP = 4'd8, CLS_OSPF = 4'd9, CLS_ICMPV6 = 4'd10, CLS_DNS = 4'd11,
    CLS_HTTP = 4'd12
  } cls_t;

  typedef enum logic [1:0] {
    NET_NONE = 2'd0, NET_ARP = 2'd1, NET_IPV4 = 2'd2, NET_IPV6 = 2'd3
  } net_t;

  // Captured frame record handed from the parser to the classifier.
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_kind;
    logic [7:0]  proto;
    logic [31:0] source_ip4;
    logic [31:0] dest_ip4;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  flags;
    logic        eth_cut;    // frame shorter than the Ethernet header
    logic        net_cut;    // network header incomplete
    logic        tcp_cut;    // TCP header incomplete
    logic        udp_cut;    // UDP header incomplete
  } rec_t;

  // Result item in output tdata order.
  typedef struct packed {
    logic        cut_short;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_ip4;
    logic [31:0] source_ip4;
    logic [7:0]  transport_number;
    logic [15:0] ether_kind;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [1:0]  net_kind;
    logic [3:0]  proto_class;
  } res_t;

  function automatic logic [5:0] hdr_bytes(input logic [3:0] nib);
    logic [5:0] n;
    n = {nib, 2'b00};
    return (n < 6'd20) ? 6'd20 : n;
  endfunction
endpackage

FILE: hw/rtl/ehc_parser.sv
// Front part: byte-wise header capture of one frame, emits a record on frame end.
// Depends on ehc_pkg.
module ehc_parser import ehc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] frame_byte,
  input  logic       frame_end,
  output logic       rec_vld,
  output rec_t       rec
);
  logic [7:0]  idx_r;
  logic [47:0] dmac_r, smac_r;
  logic [15:0] etype_r;
  logic [5:0]  ihl_r, toff_r;
  logic [7:0]  proto_r;
  logic [31:0] sip_r, dip_r;
  logic [15:0] sport_r, dport_r;
  logic [5:0]  flags_r;

  logic [47:0] dmac_nxt, smac_nxt;
  logic [15:0] etype_nxt;
  logic [5:0]  ihl_nxt, toff_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] sip_nxt, dip_nxt;
  logic [15:0] sport_nxt, dport_nxt;
  logic [5:0]  flags_nxt;
  logic [7:0]  off, tof;
  logic [1:0]  apos;
  logic        in_tr, is_tcp, is_trp;
  logic [8:0]  len, tbase, ipbase;
  logic [5:0]  seg;

  assign off = idx_r - 8'd14;
  // The ARP sender address starts at offset 14, so its byte position is off - 14.
  assign apos = off[1:0] + 2'd2;
  assign is_tcp = (proto_nxt == IPP_TCP);
  assign is_trp = is_tcp || (proto_nxt == IPP_UDP);

  always_comb begin
    dmac_nxt = dmac_r; smac_nxt = smac_r; etype_nxt = etype_r; ihl_nxt = ihl_r;
    proto_nxt = proto_r; sip_nxt = sip_r; dip_nxt = dip_r; sport_nxt = sport_r;
    dport_nxt = dport_r; flags_nxt = flags_r; toff_nxt = toff_r;
    in_tr = 1'b0; tof = 8'd0;
    if (idx_r < 8'd6) begin
      dmac_nxt[8*(5-idx_r[2:0]) +: 8] = frame_byte;
    end else if (idx_r < 8'd12) begin
      smac_nxt[8*(11-idx_r[3:0]) +: 8] = frame_byte;
    end else if (idx_r == 8'd12) begin
      etype_nxt[15:8] = frame_byte;
    end else if (idx_r == 8'd13) begin
      etype_nxt[7:0] = frame_byte;
    end else if (etype_r == ETYPE_IPV4) begin
      if (off == 8'd0) ihl_nxt = hdr_bytes(frame_byte[3:0]);
      else if (off == 8'd9) proto_nxt = frame_byte;
      else if (off >= 8'd12 && off < 8'd16) sip_nxt[8*(3-off[1:0]) +: 8] = frame_byte;
      else if (off >= 8'd16 && off < 8'd20) dip_nxt[8*(3-off[1:0]) +: 8] = frame_byte;
      in_tr = (off >= 8'd20) && (off >= {2'b00, ihl_r});
      tof = off - {2'b00, ihl_r};
    end else if (etype_r == ETYPE_IPV6) begin
      if (off == 8'd6) proto_nxt = frame_byte;
      in_tr = (off >= 8'd40);
      tof = off - 8'd40;
    end else if (etype_r == ETYPE_ARP) begin
      if (off >= 8'd14 && off < 8'd18) sip_nxt[8*(3-apos) +: 8] = frame_byte;
      else if (off >= 8'd24 && off < 8'd28) dip_nxt[8*(3-off[1:0]) +: 8] = frame_byte;
    end
    if (in_tr && is_trp) begin
      if (tof < 8'd2) sport_nxt[8*(1-tof[0]) +: 8] = frame_byte;
      else if (tof < 8'd4) dport_nxt[8*(1-tof[0]) +: 8] = frame_byte;
      else if (is_tcp && tof == 8'd12) toff_nxt = hdr_bytes(frame_byte[7:4]);
      else if (is_tcp && tof == 8'd13) flags_nxt = frame_byte[5:0];
    end
  end

  // Length checks use the header sizes as they stand after this byte.
  assign len = {1'b0, idx_r} + 9'd1;
  assign ipbase = (etype_nxt == ETYPE_IPV4) ? 9'd14 + {3'b000, ihl_nxt} :
                  (etype_nxt == ETYPE_IPV6) ? 9'd54 : 9'd42;
  assign tbase = ipbase;
  assign seg = (toff_nxt < 6'd20) ? 6'd20 : toff_nxt;

  always_comb begin
    rec.dest_mac = dmac_nxt; rec.source_mac = smac_nxt; rec.ether_kind = etype_nxt;
    rec.proto = proto_nxt; rec.source_ip4 = sip_nxt; rec.dest_ip4 = dip_nxt;
    rec.source_port = sport_nxt; rec.dest_port = dport_nxt; rec.flags = flags_nxt;
    rec.eth_cut = len < 9'd14;
    rec.net_cut = len < ipbase;
    rec.tcp_cut = (len < tbase + 9'd20) || (len < tbase + {3'b000, seg});
    rec.udp_cut = len < tbase + 9'd8;
  end
  assign rec_vld = byte_vld && frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_vld && frame_end)) begin
      idx_r <= '0; dmac_r <= '0; smac_r <= '0; etype_r <= '0; ihl_r <= '0;
      proto_r <= '0; sip_r <= '0; dip_r <= '0; sport_r <= '0; dport_r <= '0;
      flags_r <= '0; toff_r <= '0;
    end else if (byte_vld) begin
      if (idx_r != 8'hFF) idx_r <= idx_r + 8'd1;
      dmac_r <= dmac_nxt; smac_r <= smac_nxt; etype_r <= etype_nxt; ihl_r <= ihl_nxt;
      proto_r <= proto_nxt; sip_r <= sip_nxt; dip_r <= dip_nxt; sport_r <= sport_nxt;
      dport_r <= dport_nxt; flags_r <= flags_nxt; toff_r <= toff_nxt;
    end
  end
endmodule

FILE: hw/rtl/ehc_queue.sv
// Short record queue between the parser and the classifier.
// Depends on ehc_pkg.
module ehc_queue import ehc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  rec_t wr_data,
  output logic full,
  output logic rd_vld,
  input  logic rd_en,
  output rec_t rd_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  rec_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign rd_vld = (cnt_r != '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

FILE: hw/rtl/ehc_classifier.sv
// Back part: turns a captured record into the result and holds it in an output register.
// Depends on ehc_pkg.
module ehc_classifier import ehc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_vld,
  input  rec_t        rec,
  output logic        rec_take,
  input  logic [15:0] dns_port,
  input  logic [15:0] http_port,
  output logic        res_vld,
  output res_t        res,
  input  logic        res_rdy
);
  logic  vld_r;
  res_t  res_r, res_nxt;
  cls_t  cls, ncls;
  net_t  net;
  logic  cut, dns_hit, http_hit;

  assign dns_hit  = (rec.source_port == dns_port) || (rec.dest_port == dns_port);
  assign http_hit = (rec.source_port == http_port) || (rec.dest_port == http_port);

  always_comb begin
    cls = CLS_OTHER; net = NET_NONE; cut = 1'b0; ncls = CLS_OTHER;
    if (rec.eth_cut) begin
      cut = 1'b1;
    end else if (rec.ether_kind == ETYPE_IPV4 || rec.ether_kind == ETYPE_IPV6) begin
      net  = (rec.ether_kind == ETYPE_IPV4) ? NET_IPV4 : NET_IPV6;
      ncls = (rec.ether_kind == ETYPE_IPV4) ? CLS_IPV4 : CLS_IPV6;
      cls  = ncls;
      if (rec.net_cut) cut = 1'b1;
      else if (rec.proto == IPP_TCP) begin
        if (rec.tcp_cut) cut = 1'b1;
        else cls = http_hit ? CLS_HTTP : CLS_TCP;
      end else if (rec.proto == IPP_UDP) begin
        if (rec.udp_cut) cut = 1'b1;
        else cls = dns_hit ? CLS_DNS : CLS_UDP;
      end else if (net == NET_IPV4) begin
        case (rec.proto)
          IPP_ICMP: cls = CLS_ICMP;
          IPP_IGMP: cls = CLS_IGMP;
          IPP_IGRP: cls = CLS_IGRP;
          IPP_OSPF: cls = CLS_OSPF;
          default:  cls = CLS_IPV4;
        endcase
      end else if (rec.proto == IPP_ICMP6) cls = CLS_ICMPV6;
    end else if (rec.ether_kind == ETYPE_ARP) begin
      net = NET_ARP; cls = CLS_ARP; cut = rec.net_cut;
    end
    res_nxt.proto_class = cls;
    res_nxt.net_kind = net;
    res_nxt.dest_mac = rec.dest_mac;
    res_nxt.source_mac = rec.source_mac;
    res_nxt.ether_kind = rec.ether_kind;
    res_nxt.transport_number = rec.proto;
    res_nxt.source_ip4 = rec.source_ip4;
    res_nxt.dest_ip4 = rec.dest_ip4;
    res_nxt.source_port = rec.source_port;
    res_nxt.dest_port = rec.dest_port;
    res_nxt.tcp_flag_bits = rec.flags;
    res_nxt.cut_short = cut;
  end

  assign rec_take = rec_vld && (!vld_r || res_rdy);
  assign res_vld = vld_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (rec_take) vld_r <= 1'b1;
    else if (res_rdy) vld_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (rec_take) res_r <= res_nxt;
  end
endmodule

FILE: hw/rtl/ethernet_header_classifier_unit.sv
// Ethernet header classifier. Frame bytes enter one per beat on the in_ stream,
// starting at the destination MAC, with in_tlast on the last byte; one result
// beat leaves on out_ for each frame. A byte is taken every cycle while the
// record queue (QUEUE_DEPTH entries) has room, so the sustained rate is one
// byte per cycle. The parser keeps the byte index and the captured fields, the
// queue holds finished frame records, and the classifier decides the class and
// drives a registered output. The user must write ports through cfg_ only at
// idle time; the block itself does not enforce this.
// Depends on ehc_pkg, ehc_parser, ehc_queue and ehc_classifier.
module ethernet_header_classifier_unit import ehc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // frame_byte
  input  logic         in_tlast,   // frame_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // proto_class[3:0], net_kind[5:4], dest_mac[53:6], source_mac[101:54],
  // ether_kind[117:102], transport_number[125:118], source_ip4[157:126],
  // dest_ip4[189:158], source_port[205:190], dest_port[221:206],
  // tcp_flag_bits[227:222], cut_short[228], zero fill to 231
  output logic [231:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_wdata
);
  logic [15:0] dns_port_r, http_port_r;
  logic        rec_vld, q_full, q_vld, q_rd;
  rec_t        rec, q_rec;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dns_port_r <= DNS_PORT_RST;
      http_port_r <= HTTP_PORT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DNS_PORT:  dns_port_r <= cfg_wdata;
        CFG_HTTP_PORT: http_port_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Only a last byte writes the queue, but the stream is held off as a whole
  // while the queue is full.
  assign in_tready = !q_full;

  ehc_parser u_parser (
    .clk, .rst_n, .byte_vld(in_tvalid && in_tready), .frame_byte(in_tdata),
    .frame_end(in_tlast), .rec_vld, .rec
  );

  ehc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_en(rec_vld), .wr_data(rec), .full(q_full),
    .rd_vld(q_vld), .rd_en(q_rd), .rd_data(q_rec)
  );

  ehc_classifier u_cls (
    .clk, .rst_n, .rec_vld(q_vld), .rec(q_rec), .rec_take(q_rd),
    .dns_port(dns_port_r), .http_port(http_port_r),
    .res_vld(out_tvalid), .res, .res_rdy(out_tready)
  );

  assign out_tdata = {3'b000, res};
endmodule

FILE: hw/rtl/ehc_checker.sv
// Port-level checker of the header classifier, bound to the top level.
// Depends on ethernet_header_classifier_unit_assert.svh.
`include "ethernet_header_classifier_unit_assert.svh"
module ehc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [231:0] out_tdata
);
  `EHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `EHC_ASSERT_IMPL(a_cls_range, clk, rst_n, out_tvalid, out_tdata[3:0] <= 4'd12, "class out of range")
  `EHC_ASSERT_IMPL(a_cut_net, clk, rst_n, out_tvalid && out_tdata[5:4] == 2'd0, out_tdata[3:0] == 4'd0, "class without network layer")
  `EHC_ASSERT_IMPL(a_fill, clk, rst_n, out_tvalid, out_tdata[231:229] == 3'b000, "fill bits set")
endmodule

bind ethernet_header_classifier_unit ehc_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
